// ===== sv/tcf_pkg.sv =====
`default_nettype none
package tcf_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    localparam int TABLE_LEN = 24;
    localparam int TAB_W     = 30;
    localparam int CNT_W     = 5;
    localparam int VEC_W     = 44;
    localparam int ACC_W     = 34;
    localparam int SQ_W      = 48;
    localparam int SQ_STEPS  = 24;
    localparam int STATE_W   = 18;
    localparam int OUT_W     = 17;
    localparam int SAT_W     = 40;

    localparam logic signed [27:0] GYRO_GAIN   = 28'sd61520875;
    localparam logic [15:0]        ALPHA_RESET = 16'd64225;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_BLEND_ALPHA = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQRT,
        S_RLOAD,
        S_RCORD,
        S_RSTORE,
        S_PLOAD,
        S_PCORD,
        S_PSTORE,
        S_SETTLE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             load_in;
        logic             sqrt_step;
        logic             cord_load;
        logic             cord_step;
        logic             cord_store;
        logic             sel_pitch;
        logic [CNT_W-1:0] step_idx;
        logic             finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    function automatic logic [TAB_W-1:0] atan_tab(input logic [CNT_W-1:0] idx);
        logic [TAB_W-1:0] v;
        unique case (idx)
            5'd0:  v = 30'd754974720;
            5'd1:  v = 30'd445687602;
            5'd2:  v = 30'd235489088;
            5'd3:  v = 30'd119537938;
            5'd4:  v = 30'd60000934;
            5'd5:  v = 30'd30029717;
            5'd6:  v = 30'd15018523;
            5'd7:  v = 30'd7509720;
            5'd8:  v = 30'd3754917;
            5'd9:  v = 30'd1877466;
            5'd10: v = 30'd938734;
            5'd11: v = 30'd469367;
            5'd12: v = 30'd234684;
            5'd13: v = 30'd117342;
            5'd14: v = 30'd58671;
            5'd15: v = 30'd29335;
            5'd16: v = 30'd14668;
            5'd17: v = 30'd7334;
            5'd18: v = 30'd3667;
            5'd19: v = 30'd1833;
            5'd20: v = 30'd917;
            5'd21: v = 30'd458;
            5'd22: v = 30'd229;
            5'd23: v = 30'd115;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [SAT_W-1:0] v
    );
        logic signed [STATE_W-1:0] r;
        if (v > 40'sd131071) begin
            r = 18'sh1FFFF;
        end else if (v < -40'sd131072) begin
            r = 18'sh20000;
        end else begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(
        input logic signed [STATE_W-1:0] v
    );
        logic signed [OUT_W-1:0] r;
        if (v > 18'sd65535) begin
            r = 17'sh0FFFF;
        end else if (v < -18'sd65536) begin
            r = 17'sh10000;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/tcf_if.sv =====
`default_nettype none
interface tcf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_roll;
    logic signed [15:0] rate_pitch;
    logic        [15:0] elapsed_ms;

    modport source (output valid, accel_x, accel_y, accel_z, rate_roll, rate_pitch,
                    elapsed_ms, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, rate_roll, rate_pitch,
                  elapsed_ms, output ready);
endinterface

interface tcf_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] roll_out;
    logic signed [16:0] pitch_out;

    modport source (output valid, roll_out, pitch_out, input ready);
    modport sink (input valid, roll_out, pitch_out, output ready);
endinterface
`default_nettype wire

// ===== sv/tcf_ctrl.sv =====
`default_nettype none
module tcf_ctrl #(
    parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  tcf_pkg::t_dp_sts i_sts,
    output tcf_pkg::t_dp_cmd o_cmd
);
    import tcf_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.step_idx = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_cnt         = '0;
                    n_state       = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                    n_state = S_RLOAD;
                end
            end
            S_RLOAD: begin
                o_cmd.cord_load = 1'b1;
                n_cnt           = '0;
                n_state         = S_RCORD;
            end
            S_RCORD: begin
                o_cmd.cord_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NSTEPS - 1)) begin
                    n_state = S_RSTORE;
                end
            end
            S_RSTORE: begin
                o_cmd.cord_store = 1'b1;
                n_state          = S_PLOAD;
            end
            S_PLOAD: begin
                o_cmd.cord_load = 1'b1;
                o_cmd.sel_pitch = 1'b1;
                n_cnt           = '0;
                n_state         = S_PCORD;
            end
            S_PCORD: begin
                o_cmd.cord_step = 1'b1;
                o_cmd.sel_pitch = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NSTEPS - 1)) begin
                    n_state = S_PSTORE;
                end
            end
            S_PSTORE: begin
                o_cmd.cord_store = 1'b1;
                o_cmd.sel_pitch  = 1'b1;
                n_state          = S_SETTLE;
            end
            S_SETTLE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/tcf_dp.sv =====
`default_nettype none
module tcf_dp #(
    parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  tcf_pkg::t_dp_cmd   i_cmd,
    output tcf_pkg::t_dp_sts   o_sts,
    input  wire         [15:0] i_alpha,
    input  wire signed  [15:0] i_accel_x,
    input  wire signed  [15:0] i_accel_y,
    input  wire signed  [15:0] i_accel_z,
    input  wire signed  [15:0] i_rate_roll,
    input  wire signed  [15:0] i_rate_pitch,
    input  wire         [15:0] i_elapsed_ms,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic signed [16:0] o_roll_out,
    output logic signed [16:0] o_pitch_out
);
    import tcf_pkg::*;

    localparam int RS     = 24 - ANGLE_FRAC_BITS;
    localparam int GS     = 40 - ANGLE_FRAC_BITS;
    localparam int ANG_W  = 10 + ANGLE_FRAC_BITS;
    localparam int P1_W   = 33;
    localparam int P2_W   = 60;
    localparam int PRED_W = 33;
    localparam int MIX_W  = 51;
    localparam logic signed [ACC_W-1:0] ACC_90 = ACC_W'(64'sd1509949440);

    // Captured item
    logic signed [15:0] r_ax, r_ay, r_az, r_rr, r_rp;
    logic        [15:0] r_ms;

    // Square root
    logic [SQ_W-1:0] r_n, r_r, r_b;
    logic [SQ_W-1:0] w_trial;
    logic signed [31:0] w_sq_y, w_sq_z;
    logic [31:0] w_mag2;

    // CORDIC
    logic signed [VEC_W-1:0] r_x, r_y;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [VEC_W-1:0] w_x0, w_y0, w_dx, w_dy;
    logic [ACC_W-1:0]        w_acc_mag, w_acc_rnd;
    logic signed [ACC_W-1:0] w_acc_q, w_tab;

    // Blend lanes: 0 roll, 1 pitch
    logic signed [ANG_W-1:0]   r_ang   [2];
    logic signed [STATE_W-1:0] r_st    [2];
    logic signed [P1_W-1:0]    r_p1    [2];
    logic signed [P2_W-1:0]    r_p2    [2];
    logic signed [PRED_W-1:0]  r_pred  [2];
    logic signed [MIX_W-1:0]   r_ma    [2];
    logic signed [MIX_W-1:0]   r_mb    [2];
    logic signed [15:0]        w_rate  [2];
    logic [P2_W-1:0]           w_p2_mag[2];
    logic [P2_W-1:0]           w_p2_rnd[2];
    logic signed [P2_W-1:0]    w_p2_q  [2];
    logic signed [PRED_W-1:0]  w_step  [2];
    logic signed [MIX_W-1:0]   w_mix   [2];
    logic [MIX_W-1:0]          w_mx_mag[2];
    logic [MIX_W-1:0]          w_mx_rnd[2];
    logic signed [MIX_W-1:0]   w_mx_q  [2];
    logic signed [STATE_W-1:0] w_new   [2];
    logic                      r_have;
    logic [17:0]               w_beta;

    assign w_sq_y  = i_accel_y * i_accel_y;
    assign w_sq_z  = i_accel_z * i_accel_z;
    assign w_mag2  = $unsigned(w_sq_y) + $unsigned(w_sq_z);
    assign w_trial = r_r + r_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_rr <= i_rate_roll;
            r_rp <= i_rate_pitch;
            r_ms <= i_elapsed_ms;
            r_n  <= {w_mag2, 16'd0};
            r_r  <= '0;
            r_b  <= SQ_W'(1) << (SQ_W - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_n >= w_trial) begin
                r_n <= r_n - w_trial;
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

    always_comb begin
        if (i_cmd.sel_pitch) begin
            w_y0 = -(VEC_W'(r_ax) <<< 24);
            w_x0 = $signed({{(VEC_W - 40){1'b0}}, r_r[23:0], 16'd0});
        end else begin
            w_y0 = VEC_W'(r_ay) <<< 24;
            w_x0 = VEC_W'(r_az) <<< 24;
        end
        w_dx      = r_x >>> i_cmd.step_idx;
        w_dy      = r_y >>> i_cmd.step_idx;
        w_tab     = $signed({{(ACC_W - TAB_W){1'b0}}, atan_tab(i_cmd.step_idx)});
        w_acc_mag = r_acc[ACC_W-1] ? $unsigned(-r_acc) : $unsigned(r_acc);
        w_acc_rnd = (w_acc_mag + (ACC_W'(1) << (RS - 1))) >> RS;
        w_acc_q   = r_acc[ACC_W-1] ? -$signed(w_acc_rnd) : $signed(w_acc_rnd);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cord_load) begin
            if (w_x0 < 0) begin
                if (w_y0 >= 0) begin
                    r_y   <= -w_x0;
                    r_x   <= w_y0;
                    r_acc <= ACC_90;
                end else begin
                    r_y   <= w_x0;
                    r_x   <= -w_y0;
                    r_acc <= -ACC_90;
                end
            end else begin
                r_y   <= w_y0;
                r_x   <= w_x0;
                r_acc <= '0;
            end
        end else if (i_cmd.cord_step) begin
            if (r_y > 0) begin
                r_x   <= r_x + w_dy;
                r_y   <= r_y - w_dx;
                r_acc <= r_acc + w_tab;
            end else if (r_y < 0) begin
                r_x   <= r_x - w_dy;
                r_y   <= r_y + w_dx;
                r_acc <= r_acc - w_tab;
            end
        end
        if (i_cmd.cord_store) begin
            if (i_cmd.sel_pitch) begin
                r_ang[1] <= w_acc_q[ANG_W-1:0];
            end else begin
                r_ang[0] <= w_acc_q[ANG_W-1:0];
            end
        end
    end

    assign w_rate[0] = r_rr;
    assign w_rate[1] = r_rp;
    assign w_beta    = 18'd65536 - {2'b00, i_alpha};

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_p2_mag[l] = r_p2[l][P2_W-1] ? $unsigned(-r_p2[l]) : $unsigned(r_p2[l]);
            w_p2_rnd[l] = (w_p2_mag[l] + (P2_W'(1) << (GS - 1))) >> GS;
            w_p2_q[l]   = r_p2[l][P2_W-1] ? -$signed(w_p2_rnd[l]) : $signed(w_p2_rnd[l]);
            w_step[l]   = w_p2_q[l][PRED_W-1:0];
            w_mix[l]    = r_ma[l] + r_mb[l];
            w_mx_mag[l] = w_mix[l][MIX_W-1] ? $unsigned(-w_mix[l]) : $unsigned(w_mix[l]);
            w_mx_rnd[l] = (w_mx_mag[l] + (MIX_W'(1) << 15)) >> 16;
            w_mx_q[l]   = w_mix[l][MIX_W-1] ? -$signed(w_mx_rnd[l]) : $signed(w_mx_rnd[l]);
            if (r_have) begin
                w_new[l] = sat_state(w_mx_q[l][SAT_W-1:0]);
            end else begin
                w_new[l] = sat_state(SAT_W'(r_ang[l]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_p1[l]   <= w_rate[l] * $signed({1'b0, r_ms});
            r_p2[l]   <= r_p1[l] * GYRO_GAIN;
            r_pred[l] <= PRED_W'(r_st[l]) + w_step[l];
            r_ma[l]   <= $signed({2'b00, i_alpha}) * r_pred[l];
            r_mb[l]   <= $signed(w_beta) * r_ang[l];
        end
        if (i_cmd.finish) begin
            o_roll_out  <= sat_out(w_new[0]);
            o_pitch_out <= sat_out(w_new[1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_st[0]     <= '0;
            r_st[1]     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_have      <= 1'b1;
                r_st[0]     <= w_new[0];
                r_st[1]     <= w_new[1];
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !o_out_valid || i_out_ready;

endmodule
`default_nettype wire

// ===== sv/tilt_complementary_filter.sv =====
`default_nettype none
// Tilt complementary filter. Each input item carries three accelerometer axes, the roll and
// pitch gyro rates in 1/1024 rad/s and the milliseconds since the previous item; each item
// yields one result item with the roll and pitch angles in 1/256 degree (with the default
// ANGLE_FRAC_BITS), saturated to 17 bits. The accelerometer angles come from one shared
// CORDIC vectoring unit, run first for roll and then for pitch, after a bit-serial square
// root of y*y + z*z. The first item after reset loads the accelerometer angles directly;
// later items blend the gyro-integrated previous angles with weight blend_alpha/65536
// (register 0, byte address 0, reset 64225). An item occupies the block through
// the 24 square-root steps, the two CORDIC passes and any wait for a free output register;
// a new item is taken while the previous result waits in the output register.
module tilt_complementary_filter #(
    parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    tcf_in_if.sink                       i_in,
    tcf_out_if.source                    o_out,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [tcf_pkg::APB_AW-1:0]   paddr,
    input  wire  [tcf_pkg::APB_DW-1:0]   pwdata,
    output logic [tcf_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import tcf_pkg::*;

    logic [15:0] r_alpha;
    logic        w_hit;
    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;
    logic        w_in_ready;

    assign w_hit  = (paddr[APB_AW-1:2] == REG_BLEND_ALPHA);
    assign pready = 1'b1;
    assign prdata = w_hit ? {{(APB_DW - 16){1'b0}}, r_alpha} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
        end else if (psel && penable && pwrite && w_hit) begin
            r_alpha <= pwdata[15:0];
        end
    end

    assign i_in.ready = w_in_ready;

    tcf_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tcf_dp #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_alpha      (r_alpha),
        .i_accel_x    (i_in.accel_x),
        .i_accel_y    (i_in.accel_y),
        .i_accel_z    (i_in.accel_z),
        .i_rate_roll  (i_in.rate_roll),
        .i_rate_pitch (i_in.rate_pitch),
        .i_elapsed_ms (i_in.elapsed_ms),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_roll_out   (o_out.roll_out),
        .o_pitch_out  (o_out.pitch_out)
    );

endmodule
`default_nettype wire

// ===== sv/tcf_checker.sv =====
`default_nettype none
module tcf_props (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               i_in_ready,
    input wire               i_out_valid,
    input wire               i_out_ready,
    input wire signed [16:0] i_roll_out,
    input wire signed [16:0] i_pitch_out
);

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in progress");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown straight after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_roll_out) && $stable(i_pitch_out))
        else $error("stalled result changed or dropped");

    // A new result is only produced at the end of an item, when input is blocked.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while the block was idle");

endmodule

bind tilt_complementary_filter tcf_props u_tcf_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_roll_out  (o_out.roll_out),
    .i_pitch_out (o_out.pitch_out)
);
`default_nettype wire

// ===== verif/tcf_checker.sv =====
`default_nettype none
module tcf_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tcf_in_if           in_ch,
    tcf_out_if          out_ch,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [tcf_pkg::APB_AW-1:0] paddr,
    input  wire  [tcf_pkg::APB_DW-1:0] pwdata,
    input  wire         pready,
    output int          o_errors,
    output int          o_pending
);
    import tcf_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] roll;
        logic signed [OUT_W-1:0] pitch;
    } t_angles;

    localparam longint DEG_ONE = 64'sd16777216;

    longint   atan_deg[24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    t_angles     angles_due[$];
    logic [15:0] alpha;
    longint      roll_st;
    longint      pitch_st;
    logic        seeded;

    assign o_pending = angles_due.size();

    function automatic longint round_away(input longint v, input int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(input longint y, input longint x);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = y; y = -x; x = t; acc = 90 * DEG_ONE;
            end else begin
                t = -y; y = x; x = t; acc = -90 * DEG_ONE;
            end
        end
        for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0) begin
                x = x + dy; y = y - dx; acc = acc + atan_deg[i];
            end else if (y < 0) begin
                x = x - dy; y = y + dx; acc = acc - atan_deg[i];
            end
        end
        return round_away(acc, 24 - ANGLE_FRAC_BITS_DEF);
    endfunction

    function automatic longint fuse(input longint prev, input longint rate,
                                    input longint ms, input longint accel);
        longint step;
        longint a;
        step = round_away(rate * ms * 64'sd61520875, 40 - ANGLE_FRAC_BITS_DEF);
        a = longint'(alpha);
        return clip(round_away(a * (prev + step) + (65536 - a) * accel, 16),
                    -131072, 131071);
    endfunction

    task automatic track_tilt();
        longint  ax, ay, az, mag, acc_roll, acc_pitch;
        t_angles res;
        ax = in_ch.accel_x;
        ay = in_ch.accel_y;
        az = in_ch.accel_z;
        mag = root_floor(longint'(ay * ay + az * az) << 16);
        acc_roll = vector_angle(ay * DEG_ONE, az * DEG_ONE);
        acc_pitch = vector_angle(-ax * DEG_ONE, mag * 65536);
        if (!seeded) begin
            roll_st = clip(acc_roll, -131072, 131071);
            pitch_st = clip(acc_pitch, -131072, 131071);
            seeded = 1'b1;
        end else begin
            roll_st = fuse(roll_st, in_ch.rate_roll, in_ch.elapsed_ms, acc_roll);
            pitch_st = fuse(pitch_st, in_ch.rate_pitch, in_ch.elapsed_ms, acc_pitch);
        end
        res.roll = OUT_W'(clip(roll_st, -65536, 65535));
        res.pitch = OUT_W'(clip(pitch_st, -65536, 65535));
        angles_due.push_back(res);
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_angles exp_a;
        int      bad;
        bad = 0;
        if (!i_rst_n) begin
            alpha <= ALPHA_RESET;
            roll_st = 0;
            pitch_st = 0;
            seeded = 1'b0;
            angles_due.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (angles_due.size() == 0) begin
                    $error("result item with nothing expected");
                    bad = bad + 1;
                end else begin
                    exp_a = angles_due.pop_front();
                    if (out_ch.roll_out !== exp_a.roll) begin
                        $error("roll_out expected %0d got %0d", exp_a.roll, out_ch.roll_out);
                        bad = bad + 1;
                    end
                    if (out_ch.pitch_out !== exp_a.pitch) begin
                        $error("pitch_out expected %0d got %0d", exp_a.pitch,
                               out_ch.pitch_out);
                        bad = bad + 1;
                    end
                end
            end
            if (bad != 0) begin
                o_errors <= o_errors + bad;
            end
            if (in_ch.valid && in_ch.ready) begin
                track_tilt();
            end
            if (psel && penable && pwrite && pready && paddr == 4 * REG_BLEND_ALPHA) begin
                alpha <= pwdata[15:0];
            end
        end
    end
endmodule
`default_nettype wire

// ===== verif/tilt_complementary_filter_test.sv =====
`default_nettype none
module tilt_complementary_filter_test;
    import tcf_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    int                  errors;
    int                  pending;
    logic                hold_req;
    logic                no_gaps;

    tcf_in_if  in_ch ();
    tcf_out_if out_ch ();

    tilt_complementary_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tcf_checker checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: a random hold-off per item, or one long stall on request.
    initial begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (500) @(negedge i_clk);
                hold_req = 1'b0;
            end
            n = no_gaps ? 0 : $urandom_range(0, 15);
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic [15:0] rr,
                               input logic [15:0] rp, input logic [15:0] ms);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.accel_x <= ax;
        in_ch.accel_y <= ay;
        in_ch.accel_z <= az;
        in_ch.rate_roll <= rr;
        in_ch.rate_pitch <= rp;
        in_ch.elapsed_ms <= ms;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            send_sample(16'($urandom_range(0, 8000)) - 16'd4000,
                        16'($urandom_range(0, 8000)) - 16'd4000,
                        16'($urandom_range(12000, 20000)) ^ {16{sel[0]}},
                        16'($urandom_range(0, 4000)) - 16'd2000,
                        16'($urandom_range(0, 4000)) - 16'd2000,
                        16'($urandom_range(1, 40)));
        end else if (sel < 90) begin
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
        end else begin
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom_range(0, 200)));
        end
    endtask

    task automatic write_alpha(input logic [15:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(4 * REG_BLEND_ALPHA);
        pwdata <= {16'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    initial begin
        logic [15:0] alphas[6];
        alphas = '{16'd0, 16'd65535, 16'd64225, 16'($urandom), 16'd32768, 16'($urandom)};
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        no_gaps = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.accel_x = '0;
        in_ch.accel_y = '0;
        in_ch.accel_z = '0;
        in_ch.rate_roll = '0;
        in_ch.rate_pitch = '0;
        in_ch.elapsed_ms = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero vector first, then axis directions, negative x and extremes.
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'hFFFF);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd10);
        send_sample(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'd10);
        send_sample(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'd10);
        send_sample(16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'd10);
        send_sample(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd10);
        send_sample(-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd10);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 16'd0);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'hFFFF);
        send_sample(16'sd100, -16'sd32768, 16'sd0, -16'sd32768, -16'sd32768, 16'hFFFF);
        send_sample(-16'sd32768, 16'sd0, -16'sd1, 16'sd32767, 16'sd32767, 16'hFFFF);
        send_sample(16'sd5, -16'sd7000, -16'sd9000, 16'sd1, -16'sd1, 16'd1);
        send_sample(-16'sd300, 16'sd2000, 16'sd16000, 16'sd512, -16'sd512, 16'd20);
        send_sample(16'sd0, 16'sd1, -16'sd32768, 16'sd0, 16'sd0, 16'd0);
        send_sample(16'sd0, -16'sd1, -16'sd32768, 16'sd0, 16'sd0, 16'd0);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_alpha(alphas[p]);
            @(negedge i_clk);
            no_gaps = (p == 3);
            if (p == 2) hold_req = 1'b1;
            for (int k = 0; k < 205; k++) begin
                if (k == 100) no_gaps = ~no_gaps;
                send_random();
            end
            drain();
        end

        repeat (100) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== tilt_complementary_filter.f =====
sv/tcf_pkg.sv
sv/tcf_if.sv
sv/tcf_ctrl.sv
sv/tcf_dp.sv
sv/tilt_complementary_filter.sv
sv/tcf_checker.sv
verif/tcf_checker.sv
verif/tilt_complementary_filter_test.sv
